[rtl/core/aco_pkg.sv]
// Shared types and constants for the pheromone engine.
`timescale 1ns / 1ps
package aco_pkg;

  localparam int NODE_W  = 4;
  localparam int COMM_W  = 2;
  localparam int NODES   = 1 << NODE_W;
  localparam int ARC_AW  = 2 * NODE_W;
  localparam int CELL_AW = ARC_AW + COMM_W;

  localparam int PHER_W  = 32;
  localparam int DES_W   = 17;
  localparam int WT_W    = 33;
  localparam int TOT_W   = WT_W + NODE_W;
  localparam int MUL_AW  = TOT_W;
  localparam int MUL_BW  = 26;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int DIV_NW  = 40;
  localparam int DIV_DW  = 24;
  localparam int DIV_CW  = $clog2(DIV_NW);

  // evaporate divides by 100 in two halves by reciprocal multiplication:
  // floor(y / 100) == (y * RECIP_100) >> RECIP_SH for y below 100 << EV_SPLIT
  localparam int EVX_W    = 40;
  localparam int EV_SPLIT = 20;
  localparam int RECIP_SH = 32;
  localparam logic [MUL_BW-1:0] RECIP_100 = 26'd42949673;

  localparam logic [6:0]       PCT_FULL = 7'd100;
  localparam logic [DES_W-1:0] Q_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SELECT  = 2'd1,
    OP_EVAP    = 2'd2,
    OP_DEPOSIT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_EVAP  = 2'd0,
    REG_DEPC  = 2'd1,
    REG_CEIL  = 2'd2,
    REG_FLOOR = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_LD_DIV, ST_LD_WAIT, ST_LD_WR,
    ST_SA_RD, ST_SA_MUL, ST_SA_ACC, ST_THR_MUL, ST_THR_WR,
    ST_SB_RD, ST_SB_MUL, ST_SB_CMP,
    ST_EV_RD, ST_EV_MUL, ST_EV_HI, ST_EV_REM, ST_EV_LO, ST_EV_WR,
    ST_DP_RD, ST_DP_WAIT, ST_DP_WR
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [3:0]  src_node;
    logic [3:0]  node_to;
    logic [1:0]  commodity;
    logic [15:0] arc_cost;
    logic [15:0] arc_capacity;
    logic [15:0] package_request;
    logic [15:0] random_fraction;
    logic [23:0] paid_cost;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  target_node;
    logic [15:0] package_res;
  } res_t;

  typedef struct packed {
    logic              present;
    logic [15:0]       capacity;
    logic [15:0]       remaining;
  } arc_t;

  typedef struct packed {
    logic [PHER_W-1:0] pher;
    logic [DES_W-1:0]  desir;
  } cell_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/core/aco_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/aco_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module aco_div
  import aco_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] rem_q, dvs_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

[rtl/core/aco_mul.sv]
// Shared registered multiplier.
`timescale 1ns / 1ps
module aco_mul
  import aco_pkg::*;
(
  input  logic              clk_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic [MUL_PW-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

endmodule

[rtl/core/aco_pheromone_engine_unit.sv]
// Top level of the ant-colony pheromone engine: sequencer, tables and config port.
`timescale 1ns / 1ps
// Ant-colony pheromone engine. Items are commands (load arc, select, evaporate,
// deposit) given on cmd_i with start; an item is taken when start is high and
// busy is low. Every item gives exactly one result on res_o, shown for one
// cycle with done_o; the receiver must take it then. Divides and wide
// products go through one shared multiplier and one shared 40-step restoring
// divider, stepped by a small sequencer, so one item is in work at a time.
// The divide by 100 of evaporate is a reciprocal multiply on the shared
// multiplier, done in a high and a low half.
// Work per item: load runs the divider for 1/cost (skipped when cost is zero),
// deposit runs the divider for constant/paid cost, select makes two passes
// over the 16 neighbors and evaporate walks all 1024 cells. The result
// strobe follows in the first idle cycle. After reset the block sweeps its
// tables to zero with busy high; config writes are taken during that sweep.
// Config registers sit at byte addresses 0 (evaporation percent), 4 (deposit
// constant), 8 (ceiling) and 12 (floor); write them only while idle.
module aco_pheromone_engine_unit
  import aco_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [6:0]  evap_q;
  logic [15:0] depc_q, ceil_q, floor_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evap_q  <= 7'd10;
      depc_q  <= 16'd100;
      ceil_q  <= 16'd100;
      floor_q <= 16'd1;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_EVAP:  evap_q  <= pwdata[6:0];
        REG_DEPC:  depc_q  <= pwdata[15:0];
        REG_CEIL:  ceil_q  <= pwdata[15:0];
        REG_FLOOR: floor_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_EVAP:  prdata = {25'd0, evap_q};
      REG_DEPC:  prdata = {16'd0, depc_q};
      REG_CEIL:  prdata = {16'd0, ceil_q};
      REG_FLOOR: prdata = {16'd0, floor_q};
      default:   prdata = '0;
    endcase
  end

  // sequencer state and datapath registers
  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CELL_AW-1:0]  idx_q, idx_d;
  logic [NODE_W-1:0]   nb_q, nb_d;
  logic [TOT_W-1:0]    total_q, total_d, cum_q, cum_d, cum_new;
  logic [MUL_PW-1:0]   thr_q, thr_d;
  logic                elig_q, elig_d;
  arc_t                arc_q, arc_d;
  cell_t               cell_q, cell_d;
  res_t                res_q, res_d;
  logic                done_q, done_d;
  logic [EVX_W-1:0]    evx_q, evx_d;
  logic [EV_SPLIT-1:0] qh_q, qh_d;
  logic [6:0]          rh_q, rh_d;

  // memories and shared units
  logic               cell_we, arc_we;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  logic [ARC_AW-1:0]  arc_waddr, arc_raddr;
  cell_t              cell_wdata, cell_rdata;
  arc_t               arc_wdata, arc_rdata;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  logic               div_start;
  logic [DIV_NW-1:0]  div_n, div_q;
  logic [DIV_DW-1:0]  div_d;
  div_stat_t          div_stat;

  // derived values
  logic                accept;
  logic [WT_W-1:0]     weight;
  logic [6:0]          rate, keep;
  logic [PHER_W-1:0]   lo, hi, evap_p, dep_p;
  logic [DIV_NW:0]     dep_sum;
  logic [TOT_W+15:0]   scaled;
  logic                hit;
  logic [15:0]         pkg;
  logic                last_nb;
  logic [EV_SPLIT-1:0] ev_qh, ev_rfull;
  logic [EVX_W-1:0]    ev_quot;

  assign busy    = state_q != ST_IDLE;
  assign accept  = start && !busy;
  assign weight  = mul_p[16 +: WT_W];
  assign rate    = (evap_q > PCT_FULL) ? PCT_FULL : evap_q;
  assign keep    = PCT_FULL - rate;
  assign lo      = {floor_q, 16'd0};
  assign hi      = {ceil_q, 16'd0};
  // evaporate: x = p * keep; x / 100 = (xh / 100) << 20 + ((xh % 100) << 20 + xl) / 100
  assign ev_qh    = mul_p[RECIP_SH +: EV_SPLIT];
  assign ev_rfull = evx_q[EVX_W-1:EV_SPLIT] - ev_qh * EV_SPLIT'(PCT_FULL);
  assign ev_quot  = {qh_q, mul_p[RECIP_SH +: EV_SPLIT]};
  assign evap_p  = (ev_quot[PHER_W-1:0] < lo) ? lo : ev_quot[PHER_W-1:0];
  assign dep_sum = {1'b0, div_q} + (DIV_NW + 1)'(cell_rdata.pher);
  assign dep_p   = (cmd_q.paid_cost == '0 || dep_sum > (DIV_NW + 1)'(hi)) ?
                   hi : dep_sum[PHER_W-1:0];
  // roulette test: cum * 65535 >= r * total
  assign cum_new = cum_q + (elig_q ? TOT_W'(weight) : '0);
  assign scaled  = {cum_new, 16'd0} - (TOT_W + 16)'(cum_new);
  assign hit     = elig_q && ((MUL_PW)'(scaled) >= thr_q);
  assign pkg     = (cmd_q.package_request < arc_q.remaining) ?
                   cmd_q.package_request : arc_q.remaining;
  assign last_nb = nb_q == NODE_W'(NODES - 1);

  aco_ram #(.WIDTH($bits(cell_t)), .DEPTH(1 << CELL_AW)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  aco_ram #(.WIDTH($bits(arc_t)), .DEPTH(1 << ARC_AW)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (arc_wdata),
    .raddr_i (arc_raddr),
    .rdata_o (arc_rdata)
  );

  aco_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  aco_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .stat_o     (div_stat),
    .quot_o     (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (idx_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.operation)
            OP_LOAD:    state_d = ST_LD_DIV;
            OP_SELECT:  state_d = ST_SA_RD;
            OP_EVAP:    state_d = ST_EV_RD;
            OP_DEPOSIT: state_d = ST_DP_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_DIV:  state_d = (cmd_q.arc_cost == '0) ? ST_LD_WR : ST_LD_WAIT;
      ST_LD_WAIT: if (div_stat.done) state_d = ST_LD_WR;
      ST_LD_WR:   state_d = ST_IDLE;
      ST_SA_RD:   state_d = ST_SA_MUL;
      ST_SA_MUL:  state_d = ST_SA_ACC;
      ST_SA_ACC:  state_d = last_nb ? ST_THR_MUL : ST_SA_RD;
      ST_THR_MUL: state_d = ST_THR_WR;
      ST_THR_WR:  state_d = ST_SB_RD;
      ST_SB_RD:   state_d = ST_SB_MUL;
      ST_SB_MUL:  state_d = ST_SB_CMP;
      ST_SB_CMP:  state_d = (hit || last_nb) ? ST_IDLE : ST_SB_RD;
      ST_EV_RD:   state_d = ST_EV_MUL;
      ST_EV_MUL:  state_d = ST_EV_HI;
      ST_EV_HI:   state_d = ST_EV_REM;
      ST_EV_REM:  state_d = ST_EV_LO;
      ST_EV_LO:   state_d = ST_EV_WR;
      ST_EV_WR:   state_d = (idx_q == '1) ? ST_IDLE : ST_EV_RD;
      ST_DP_RD:   state_d = ST_DP_WAIT;
      ST_DP_WAIT: if (div_stat.done) state_d = ST_DP_WR;
      ST_DP_WR:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    nb_d       = nb_q;
    total_d    = total_q;
    cum_d      = cum_q;
    thr_d      = thr_q;
    elig_d     = elig_q;
    arc_d      = arc_q;
    cell_d     = cell_q;
    res_d      = res_q;
    evx_d      = evx_q;
    qh_d       = qh_q;
    rh_d       = rh_q;
    done_d     = 1'b0;
    cell_we    = 1'b0;
    arc_we     = 1'b0;
    cell_waddr = {cmd_q.src_node, cmd_q.node_to, cmd_q.commodity};
    arc_waddr  = {cmd_q.src_node, cmd_q.node_to};
    cell_wdata = '0;
    arc_wdata  = '0;
    cell_raddr = {cmd_q.src_node, cmd_q.node_to, cmd_q.commodity};
    arc_raddr  = {cmd_q.src_node, cmd_q.node_to};
    mul_a      = MUL_AW'(cell_rdata.pher);
    mul_b      = MUL_BW'(cell_rdata.desir);
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    case (state_q)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = idx_q;
        arc_we     = idx_q[CELL_AW-1:ARC_AW] == '0;
        arc_waddr  = idx_q[ARC_AW-1:0];
        idx_d      = idx_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          nb_d    = '0;
          total_d = '0;
          cum_d   = '0;
        end
      end
      ST_LD_DIV: begin
        div_start = cmd_q.arc_cost != '0;
        div_n     = DIV_NW'(Q_ONE);
        div_d     = DIV_DW'(cmd_q.arc_cost);
      end
      ST_LD_WR: begin
        cell_we          = 1'b1;
        cell_wdata.pher  = lo;
        cell_wdata.desir = (cmd_q.arc_cost == '0) ? Q_ONE : div_q[DES_W-1:0];
        arc_we              = 1'b1;
        arc_wdata.present   = 1'b1;
        arc_wdata.capacity  = cmd_q.arc_capacity;
        arc_wdata.remaining = cmd_q.arc_capacity;
        res_d  = '0;
        done_d = 1'b1;
      end
      ST_SA_RD, ST_SB_RD: begin
        cell_raddr = {cmd_q.src_node, nb_q, cmd_q.commodity};
        arc_raddr  = {cmd_q.src_node, nb_q};
      end
      ST_SA_MUL, ST_SB_MUL: begin
        cell_raddr = {cmd_q.src_node, nb_q, cmd_q.commodity};
        arc_raddr  = {cmd_q.src_node, nb_q};
        elig_d     = arc_rdata.present && (arc_rdata.remaining != '0);
        arc_d      = arc_rdata;
      end
      ST_SA_ACC: begin
        total_d = total_q + (elig_q ? TOT_W'(weight) : '0);
        nb_d    = nb_q + 1'b1;
      end
      ST_THR_MUL: begin
        mul_a = total_q;
        mul_b = MUL_BW'(cmd_q.random_fraction);
      end
      ST_THR_WR: begin
        thr_d = mul_p;
        nb_d  = '0;
        cum_d = '0;
      end
      ST_SB_CMP: begin
        cum_d = cum_new;
        nb_d  = nb_q + 1'b1;
        if (hit) begin
          arc_we              = 1'b1;
          arc_waddr           = {cmd_q.src_node, nb_q};
          arc_wdata.present   = arc_q.present;
          arc_wdata.capacity  = arc_q.capacity;
          arc_wdata.remaining = arc_q.remaining - pkg;
          res_d.found         = 1'b1;
          res_d.target_node   = nb_q;
          res_d.package_res   = pkg;
          done_d              = 1'b1;
        end else if (last_nb) begin
          res_d  = '0;
          done_d = 1'b1;
        end
      end
      ST_EV_RD: begin
        cell_raddr = idx_q;
        arc_raddr  = idx_q[ARC_AW-1:0];
      end
      ST_EV_MUL: begin
        cell_d = cell_rdata;
        arc_d  = arc_rdata;
        mul_b  = MUL_BW'(keep);
      end
      ST_EV_HI: begin
        // x = p * keep is on the multiplier output; divide its high half
        evx_d = mul_p[EVX_W-1:0];
        mul_a = MUL_AW'(mul_p[EVX_W-1:EV_SPLIT]);
        mul_b = RECIP_100;
      end
      ST_EV_REM: begin
        qh_d = ev_qh;
        rh_d = ev_rfull[6:0];
      end
      ST_EV_LO: begin
        mul_a = MUL_AW'({rh_q, evx_q[EV_SPLIT-1:0]});
        mul_b = RECIP_100;
      end
      ST_EV_WR: begin
        cell_we             = 1'b1;
        cell_waddr          = idx_q;
        cell_wdata.pher     = evap_p;
        cell_wdata.desir    = cell_q.desir;
        // the arc table is restored alongside the first cells
        arc_we              = idx_q[CELL_AW-1:ARC_AW] == '0;
        arc_waddr           = idx_q[ARC_AW-1:0];
        arc_wdata.present   = arc_q.present;
        arc_wdata.capacity  = arc_q.capacity;
        arc_wdata.remaining = arc_q.capacity;
        idx_d               = idx_q + 1'b1;
        if (idx_q == '1) begin
          res_d  = '0;
          done_d = 1'b1;
        end
      end
      ST_DP_RD: begin
        div_start = 1'b1;
        div_n     = {8'd0, depc_q, 16'd0};
        div_d     = cmd_q.paid_cost;
      end
      ST_DP_WR: begin
        cell_we          = 1'b1;
        cell_wdata.pher  = dep_p;
        cell_wdata.desir = cell_rdata.desir;
        res_d  = '0;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    nb_q    <= nb_d;
    total_q <= total_d;
    cum_q   <= cum_d;
    thr_q   <= thr_d;
    elig_q  <= elig_d;
    arc_q   <= arc_d;
    cell_q  <= cell_d;
    evx_q   <= evx_d;
    qh_q    <= qh_d;
    rh_q    <= rh_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an item in work");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.found |-> res_o.target_node == '0 && res_o.package_res == '0)
    else $error("non-found result carries data");

  a_found_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.found |-> cmd_q.operation == OP_SELECT)
    else $error("found set on a non-select item");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_stat.busy)
    else $error("divider still running while idle");

endmodule
